>>> design/hlzd_pkg.sv
// ----------------------------------------------------------------------------
// hlzd_pkg: shared types and constants of the halfword LZ decoder
// Holds the decode phase and sequencer encodings and the fixed field layout
// of the compressed stream.
// ----------------------------------------------------------------------------
package hlzd_pkg;

  // Width of one halfword of the compressed and decoded streams.
  localparam int unsigned WORD_W = 16;

  // A back-reference token: distance above, length code below.
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned DIST_W = WORD_W - LEN_W;

  // Copy length is the length code plus this bias.
  localparam int unsigned LEN_BIAS = 2;
  localparam int unsigned RUN_W    = LEN_W + 1;

  // Number of raw halfwords announced by a zero control word.
  localparam int unsigned RAW_RUN_LENGTH = 16;
  localparam int unsigned RAW_W          = 5;

  // Flag accumulator: 16 flags above a marker bit, bit 16 is the current flag.
  localparam int unsigned ACC_W = WORD_W + 1;
  localparam logic [ACC_W-1:0] ACC_TOP = 17'h10000;

  // Byte count output and its saturation value.
  localparam int unsigned BYTES_W = 25;
  localparam logic [BYTES_W-1:0] BYTES_MAX = 25'h1FFFFFE;

  // Decode phase of the stream parser.
  typedef enum logic [3:0] {
    PH_CONTROL = 4'b0001,
    PH_RAW     = 4'b0010,
    PH_FLAGGED = 4'b0100,
    PH_HALT    = 4'b1000
  } phase_t;

  // Sequencer of the history copy unit.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_WRITE = 3'b100
  } seq_t;

endpackage

>>> design/halfword_lz_decoder.sv
// ----------------------------------------------------------------------------
// halfword_lz_decoder: streaming LZ decoder over 16-bit halfwords
// Parses control words, literals, raw runs and back-reference tokens and
// emits decoded halfwords, keeping a history memory for the copies.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Beat contents
//   --------+-----------+-----------------------------------------------------
//   in_     | input     | compressed_word
//   out_    | output    | decoded_halfword, last_of_run, stream_end,
//           |           | output_bytes, bad_reference
//
// Control words, literals, raw halfwords, end tokens and rejected tokens
// are handled in the idle state. Each halfword of a back reference is read
// from the history in ST_READ (registered read), then written back and
// loaded into the output register in ST_WRITE. The input is not ready
// during a copy. A stalled output holds the sequencer in ST_WRITE and the
// input. Reset clears all control state; the history memory is not cleared.
//
module halfword_lz_decoder
  import hlzd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 2048,
  parameter int unsigned COUNT_WIDTH   = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_W-1:0]    in_compressed_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    out_decoded_halfword,
  output logic                 out_last_of_run,
  output logic                 out_stream_end,
  output logic [BYTES_W-1:0]   out_output_bytes,
  output logic                 out_bad_reference
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned BW = (COUNT_WIDTH + 1 > BYTES_W) ? COUNT_WIDTH + 1 : BYTES_W;
  localparam logic [AW-1:0] IDX_LAST = AW'(HISTORY_DEPTH - 1);

  // Control state.
  phase_t                  phase_r,   phase_nxt;
  seq_t                    seq_r,     seq_nxt;
  logic [ACC_W-1:0]        acc_r,     acc_nxt;
  logic [RAW_W-1:0]        raw_rem_r, raw_rem_nxt;
  logic [AW-1:0]           wr_idx_r,  wr_idx_nxt;
  logic [COUNT_WIDTH-1:0]  count_r,   count_nxt;
  logic [RUN_W-1:0]        len_rem_r, len_rem_nxt;
  logic [DIST_W-1:0]       dist_r,    dist_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Output payload registers.
  logic [WORD_W-1:0]       out_word_r;
  logic                    out_last_r;
  logic                    out_end_r;
  logic                    out_bad_r;
  logic [BYTES_W-1:0]      out_bytes_r;

  // History memory and its registered read data.
  logic [WORD_W-1:0]       hist_mem [HISTORY_DEPTH];
  logic [WORD_W-1:0]       rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic [AW:0]             rd_addr_wrap;
  logic                    mem_we;
  logic [WORD_W-1:0]       mem_wdata;

  // Result loading controls.
  logic                    out_free;
  logic                    out_load;
  logic [WORD_W-1:0]       load_word;
  logic                    load_last;
  logic                    load_end;
  logic                    load_bad;
  logic                    count_inc;
  logic                    in_beat;
  logic [ACC_W-1:0]        acc_shift;
  logic [DIST_W-1:0]       tok_dist;
  logic [BW-1:0]           bytes_wide;
  logic [BYTES_W-1:0]      bytes_sat;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (seq_r == ST_IDLE) && out_free;
  assign in_beat  = in_valid && in_ready;
  assign tok_dist = in_compressed_word[WORD_W-1:LEN_W];
  assign acc_shift = {acc_r[ACC_W-2:0], 1'b0};

  // Source address of the copy: write index minus distance, modulo depth.
  assign rd_addr_wrap = ({1'b0, wr_idx_r} >= {1'b0, AW'(dist_r)})
                      ? ({1'b0, wr_idx_r} - {1'b0, AW'(dist_r)})
                      : ({1'b0, wr_idx_r} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, AW'(dist_r)});
  assign rd_addr = rd_addr_wrap[AW-1:0];

  // Parser and copy sequencer.
  always_comb begin
    phase_nxt   = phase_r;
    seq_nxt     = seq_r;
    acc_nxt     = acc_r;
    raw_rem_nxt = raw_rem_r;
    len_rem_nxt = len_rem_r;
    dist_nxt    = dist_r;
    mem_we      = 1'b0;
    mem_wdata   = rd_data_r;
    out_load    = 1'b0;
    load_word   = rd_data_r;
    load_last   = 1'b1;
    load_end    = 1'b0;
    load_bad    = 1'b0;
    count_inc   = 1'b0;

    case (seq_r)
      ST_IDLE: begin
        if (in_beat) begin
          case (phase_r)
            PH_CONTROL: begin
              if (in_compressed_word == '0) begin
                raw_rem_nxt = RAW_W'(RAW_RUN_LENGTH);
                phase_nxt   = PH_RAW;
              end else begin
                acc_nxt   = {in_compressed_word, 1'b1};
                phase_nxt = PH_FLAGGED;
              end
            end
            PH_RAW: begin
              mem_we      = 1'b1;
              mem_wdata   = in_compressed_word;
              out_load    = 1'b1;
              load_word   = in_compressed_word;
              count_inc   = 1'b1;
              raw_rem_nxt = (raw_rem_r != '0) ? raw_rem_r - 1'b1 : raw_rem_r;
              if (raw_rem_nxt == '0) begin
                phase_nxt = PH_CONTROL;
              end
            end
            PH_FLAGGED: begin
              if ((acc_r & ACC_TOP) == '0) begin
                // Literal halfword.
                mem_we    = 1'b1;
                mem_wdata = in_compressed_word;
                out_load  = 1'b1;
                load_word = in_compressed_word;
                count_inc = 1'b1;
                acc_nxt   = acc_shift;
                if (acc_shift == ACC_TOP || acc_shift == '0) begin
                  phase_nxt = PH_CONTROL;
                end
              end else if (in_compressed_word == '0) begin
                // End token.
                out_load  = 1'b1;
                load_word = '0;
                load_end  = 1'b1;
                phase_nxt = PH_HALT;
              end else if (tok_dist == '0 ||
                           COUNT_WIDTH'(tok_dist) > count_r) begin
                // Rejected back reference.
                out_load  = 1'b1;
                load_word = '0;
                load_bad  = 1'b1;
                phase_nxt = PH_HALT;
              end else begin
                // Start a copy; the flag advances now since the phase is
                // only looked at again once the copy is done.
                dist_nxt    = tok_dist;
                len_rem_nxt = RUN_W'(in_compressed_word[LEN_W-1:0]) + RUN_W'(LEN_BIAS);
                seq_nxt     = ST_READ;
                acc_nxt     = acc_shift;
                if (acc_shift == ACC_TOP || acc_shift == '0) begin
                  phase_nxt = PH_CONTROL;
                end
              end
            end
            default: begin
              // Halted: beats are taken and dropped.
              phase_nxt = phase_r;
            end
          endcase
        end
      end
      ST_READ: begin
        seq_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          mem_we      = 1'b1;
          mem_wdata   = rd_data_r;
          out_load    = 1'b1;
          load_word   = rd_data_r;
          load_last   = (len_rem_r == RUN_W'(1));
          count_inc   = 1'b1;
          len_rem_nxt = len_rem_r - 1'b1;
          seq_nxt     = (len_rem_r == RUN_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        seq_nxt = ST_IDLE;
      end
    endcase
  end

  // Write index wraps; halfword count saturates.
  assign wr_idx_nxt = !mem_we ? wr_idx_r
                    : (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
  assign count_nxt  = (count_inc && count_r != '1) ? count_r + 1'b1 : count_r;

  // Byte count of the result, saturating.
  assign bytes_wide = BW'({count_nxt, 1'b0});
  assign bytes_sat  = (bytes_wide > BW'(BYTES_MAX)) ? BYTES_MAX : bytes_wide[BYTES_W-1:0];

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CONTROL;
      seq_r       <= ST_IDLE;
      acc_r       <= '0;
      raw_rem_r   <= '0;
      wr_idx_r    <= '0;
      count_r     <= '0;
      len_rem_r   <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      acc_r       <= acc_nxt;
      raw_rem_r   <= raw_rem_nxt;
      wr_idx_r    <= wr_idx_nxt;
      count_r     <= count_nxt;
      len_rem_r   <= len_rem_nxt;
      dist_r      <= dist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r  <= load_word;
      out_last_r  <= load_last;
      out_end_r   <= load_end;
      out_bad_r   <= load_bad;
      out_bytes_r <= bytes_sat;
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wr_idx_r] <= mem_wdata;
    end
    if (seq_r == ST_READ) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_decoded_halfword = out_word_r;
  assign out_last_of_run      = out_last_r;
  assign out_stream_end       = out_end_r;
  assign out_output_bytes     = out_bytes_r;
  assign out_bad_reference    = out_bad_r;

  // Once halted, the parser never resumes.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("decoder left the halted phase");

  // A copy only runs with a distance that passed the check.
  a_copy_dist_ok: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == ST_READ |-> (dist_r != '0 && COUNT_WIDTH'(dist_r) <= count_r))
    else $error("copy started with an invalid distance");

  // The copy unit always has halfwords left while it is busy.
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r != ST_IDLE |-> len_rem_r != '0)
    else $error("copy unit busy with nothing left to copy");

  // End and error results are distinct and always close their beat group.
  a_end_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_end_r || out_bad_r)) |-> (!(out_end_r && out_bad_r) && out_last_r))
    else $error("malformed end or error result");

  // The input is never taken while a copy is in progress.
  a_no_input_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == ST_WRITE |-> !in_ready)
    else $error("input accepted during a copy");

endmodule

>>> bench/halfword_lz_decoder_test.sv
// ----------------------------------------------------------------------------
// halfword_lz_decoder_test: self-checking bench for the halfword LZ decoder
// Feeds one continuous compressed stream built from the bench's own view of
// the parser state: a raw run, back references with overlap and extreme
// lengths, then random groups of literals and copies under three sender and
// receiver stall profiles. The stream is closed by an end token or by a
// rejected distance, and a few words after the stop must be ignored. Every
// output beat is checked field by field against a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module halfword_lz_decoder_test;
  import hlzd_pkg::*;

  localparam int unsigned HIST_DEPTH = 2048;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned MAX_DIST   = (1 << DIST_W) - 1;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // A zero control word opens a raw run, a zero token ends the stream.
  localparam logic [WORD_W-1:0] CTRL_RAW  = '0;
  localparam logic [WORD_W-1:0] END_TOKEN = '0;
  // Control word whose first flag selects a token.
  localparam logic [WORD_W-1:0] CTRL_TOKEN_FIRST = 16'h8000;

  typedef enum int {
    STOP_END,
    STOP_ZERO_DIST,
    STOP_FAR_DIST
  } stop_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0]  halfword;
    logic               last;
    logic               stream_end;
    logic [BYTES_W-1:0] bytes;
    logic               bad_ref;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WORD_W-1:0] in_compressed_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] out_decoded_halfword;
  logic out_last_of_run;
  logic out_stream_end;
  logic [BYTES_W-1:0] out_output_bytes;
  logic out_bad_reference;

  // Predicted decoder state.
  logic [WORD_W-1:0]  hist [HIST_DEPTH];
  logic [HIST_AW-1:0] wr_idx = '0;
  logic [ACC_W-1:0]   flags = '0;
  phase_t             phase = PH_CONTROL;
  logic [RAW_W-1:0]   raw_left = '0;
  logic [COUNT_W-1:0] written = '0;
  bit                 halted = 1'b0;

  beat_t expected_beats[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  stop_kind_t  stop_kind = STOP_END;

  halfword_lz_decoder #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .COUNT_WIDTH  (COUNT_W)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_compressed_word  (in_compressed_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_decoded_halfword(out_decoded_halfword),
    .out_last_of_run     (out_last_of_run),
    .out_stream_end      (out_stream_end),
    .out_output_bytes    (out_output_bytes),
    .out_bad_reference   (out_bad_reference)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Byte count reported with every beat, saturating.
  function automatic logic [BYTES_W-1:0] byte_count();
    logic [BYTES_W:0] dbl;
    dbl = {written, 1'b0};
    return (dbl > BYTES_MAX) ? BYTES_MAX : dbl[BYTES_W-1:0];
  endfunction

  // Store one decoded halfword in the history and queue its beat.
  function automatic void emit_halfword(logic [WORD_W-1:0] v, logic last);
    hist[wr_idx] = v;
    wr_idx = wr_idx + 1'b1;
    if (written != '1)
      written = written + 1'b1;
    expected_beats.push_back('{v, last, 1'b0, byte_count(), 1'b0});
  endfunction

  // Move to the next flag; an exhausted group returns to the control phase.
  function automatic void next_flag();
    flags = {flags[ACC_W-2:0], 1'b0};
    if (flags == ACC_TOP || flags == '0)
      phase = PH_CONTROL;
  endfunction

  // Work out the beats that one accepted compressed word produces.
  function automatic void decode_word(logic [WORD_W-1:0] w);
    logic [DIST_W-1:0]  ref_dist;
    logic [RUN_W-1:0]   run_len;
    logic [HIST_AW-1:0] rd_idx;
    if (halted)
      return;
    case (phase)
      PH_CONTROL: begin
        if (w == CTRL_RAW) begin
          raw_left = RAW_W'(RAW_RUN_LENGTH);
          phase = PH_RAW;
        end else begin
          flags = {w, 1'b1};
          phase = PH_FLAGGED;
        end
      end
      PH_RAW: begin
        emit_halfword(w, 1'b1);
        raw_left = raw_left - 1'b1;
        if (raw_left == '0)
          phase = PH_CONTROL;
      end
      default: begin
        if (!flags[ACC_W-1]) begin
          emit_halfword(w, 1'b1);
          next_flag();
        end else if (w == END_TOKEN) begin
          halted = 1'b1;
          phase = PH_HALT;
          expected_beats.push_back('{'0, 1'b1, 1'b1, byte_count(), 1'b0});
        end else begin
          ref_dist = w[WORD_W-1:LEN_W];
          run_len = RUN_W'(w[LEN_W-1:0]) + RUN_W'(LEN_BIAS);
          if (ref_dist == '0 || ref_dist > written) begin
            halted = 1'b1;
            phase = PH_HALT;
            expected_beats.push_back('{'0, 1'b1, 1'b0, byte_count(), 1'b1});
          end else begin
            // The source trails the write index, so overlapping copies
            // replicate the halfwords they have just written.
            for (int i = 0; i < run_len; i++) begin
              rd_idx = wr_idx - HIST_AW'(ref_dist);
              emit_halfword(hist[rd_idx], (i == run_len - 1));
            end
            next_flag();
          end
        end
      end
    endcase
  endfunction

  // Pick a well-formed next word for the current parser state.
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned roll;
    int unsigned reach;
    logic [DIST_W-1:0] ref_dist;
    logic [LEN_W-1:0]  len_code;
    roll = $urandom_range(99);
    if (phase == PH_CONTROL) begin
      if (roll < 20)
        return CTRL_RAW;
      else if (roll < 28)
        return '1;
      else if (roll < 33)
        return CTRL_TOKEN_FIRST;
      return WORD_W'($urandom_range(1, (1 << WORD_W) - 1));
    end
    if (phase == PH_RAW || !flags[ACC_W-1])
      return WORD_W'($urandom_range((1 << WORD_W) - 1));
    // Token slot: only distances that reach written history.
    reach = (written > MAX_DIST) ? MAX_DIST : written;
    if (roll < 30)
      ref_dist = DIST_W'($urandom_range(1, (reach < 4) ? reach : 4));
    else
      ref_dist = DIST_W'($urandom_range(1, reach));
    if ($urandom_range(99) < 70)
      len_code = LEN_W'($urandom_range(7));
    else
      len_code = LEN_W'($urandom_range(8, (1 << LEN_W) - 1));
    return {ref_dist, len_code};
  endfunction

  // Offer one word, with random idle cycles in front, and wait until it is taken.
  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_compressed_word <= w;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    decode_word(w);
    items_sent++;
  endtask

  // A raw run carrying the extreme halfword values.
  task automatic test_raw_run();
    logic [WORD_W-1:0] vals [RAW_RUN_LENGTH];
    vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h5555, 16'hAAAA,
             16'h7FFF, 16'hFFFE, 16'h0000, 16'h1234, 16'hFFFF, 16'h00FF,
             16'hFF00, 16'h8001, 16'h0F0F, 16'hF0F0};
    send_word(CTRL_RAW);
    foreach (vals[i])
      send_word(vals[i]);
  endtask

  // Back references: overlapping longest copy, farthest distance, partial
  // overlap, then literals of both extremes inside the same flag group.
  task automatic test_back_references();
    send_word(16'hE000);
    send_word({DIST_W'(1), LEN_W'((1 << LEN_W) - 1)});
    send_word({written[DIST_W-1:0], LEN_W'(0)});
    send_word({DIST_W'(17), LEN_W'(16)});
    send_word(16'hFFFF);
    send_word(16'h0000);
  endtask

  // Random well-formed stream under one stall profile.
  task automatic test_random_stream(input int unsigned sender_pct,
                                    input int unsigned receiver_pct,
                                    input int unsigned count);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (count)
      send_word(pick_word());
  endtask

  // Close the stream with an end token or a rejected distance, then check
  // that later words produce nothing.
  task automatic test_stream_stop();
    logic [LEN_W-1:0] len_code;
    while (!(phase == PH_FLAGGED && flags[ACC_W-1]))
      send_word((phase == PH_CONTROL) ? CTRL_TOKEN_FIRST : pick_word());
    stop_kind = stop_kind_t'($urandom_range(2));
    if (stop_kind == STOP_FAR_DIST && written >= MAX_DIST)
      stop_kind = STOP_ZERO_DIST;
    len_code = LEN_W'($urandom_range(1, (1 << LEN_W) - 1));
    case (stop_kind)
      STOP_END:       send_word(END_TOKEN);
      STOP_ZERO_DIST: send_word({DIST_W'(0), len_code});
      default:        send_word({DIST_W'(written + 1'b1), len_code});
    endcase
    send_word(CTRL_RAW);
    repeat (5)
      send_word(WORD_W'($urandom_range((1 << WORD_W) - 1)));
  endtask

  task automatic compare_field(input string field, input logic [BYTES_W-1:0] exp_val,
                               input logic [BYTES_W-1:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, exp_val, act_val);
    end
  endtask

  // Receiver stalls.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Check every output beat against the oldest prediction.
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected beat, expected none, actual halfword 0x%0h",
                 $time, out_decoded_halfword);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        compare_field("decoded_halfword", want.halfword, out_decoded_halfword);
        compare_field("last_of_run", want.last, out_last_of_run);
        compare_field("stream_end", want.stream_end, out_stream_end);
        compare_field("output_bytes", want.bytes, out_output_bytes);
        compare_field("bad_reference", want.bad_ref, out_bad_reference);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.",
               cycle_count, expected_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 80;
    test_raw_run();
    test_back_references();
    test_random_stream(13, 80, 117);
    test_random_stream(80, 13, 117);
    test_random_stream(0, 0, 116);
    test_stream_stop();

    // Let the last copies drain, then watch for stray beats.
    in_valid <= 1'b0;
    while (expected_beats.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d compressed words, checked %0d decoded beats, %0d halfwords in history.",
             items_sent, beats_checked, written);
    $display("Stream closed by %s, followed by ignored words.", stop_kind.name());
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
